// File: rtl/core/hsv2rgb_pkg.sv
// Package for the HSV to RGB colour converter.
// Holds the beat types, fixed-point constants and hue sector codes.
// Depends on nothing; used by hsv_to_rgb_converter_core.
`default_nettype none

package hsv2rgb_pkg;

	// One in Q1.16 for saturation and brightness.
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// Hue sectors, each one sixth of a turn.
	localparam logic [2:0] SECTOR_RED_YELLOW    = 3'd0;
	localparam logic [2:0] SECTOR_YELLOW_GREEN  = 3'd1;
	localparam logic [2:0] SECTOR_GREEN_CYAN    = 3'd2;
	localparam logic [2:0] SECTOR_CYAN_BLUE     = 3'd3;
	localparam logic [2:0] SECTOR_BLUE_MAGENTA  = 3'd4;

	typedef struct packed {
		logic [15:0] hue;
		logic [16:0] saturation;
		logic [16:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// Clamp a Q1.16 quantity to the range zero to one.
	function automatic logic [16:0] sat_unit(input logic [16:0] val);
		sat_unit = (val > ONE_Q16) ? ONE_Q16 : val;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/hsv_to_rgb_converter_core.sv
// HSV to RGB colour converter: four register stages, one beat per clock.
// The result strobe is registered: a beat passes the stage 1, 2 and 3 registers before done rises.
// Throughput: one beat per clock, set by a fully pipelined datapath whose two
// multipliers sit in separate stages; busy is never raised and the receiver cannot stall.
// Reset: arst_n clears every valid bit at once; no beat survives a reset.
// Depends on hsv2rgb_pkg for beat types, constants and sector codes.
`default_nettype none

module hsv_to_rgb_converter_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire hsv2rgb_pkg::hsv_t  hsv,
	output logic                    done,
	output hsv2rgb_pkg::rgb_t       rgb
);
	import hsv2rgb_pkg::*;

	// The pipeline never holds anything back, so a beat may enter every cycle.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ------------------------------------------------------------------
	// Stage 1: clamp saturation and brightness, split the hue into its
	// sector and the fraction within it, and form chroma = value * sat.
	// Hue times six is at most 393210, so the sector is never above five.
	// In odd sectors the secondary weight runs downwards, so it becomes
	// one minus the fraction; that is why the weight needs 17 bits.
	// ------------------------------------------------------------------
	logic [16:0] sat_c;
	logic [16:0] val_c;
	logic [18:0] hue6_c;
	logic [16:0] weight_c;
	logic [33:0] chroma_full_c;

	assign sat_c         = sat_unit(hsv.saturation);
	assign val_c         = sat_unit(hsv.brightness);
	assign hue6_c        = {3'b000, hsv.hue} * 19'd6;
	assign weight_c      = hue6_c[16] ? (ONE_Q16 - {1'b0, hue6_c[15:0]})
	                                  : {1'b0, hue6_c[15:0]};
	assign chroma_full_c = {17'd0, val_c} * {17'd0, sat_c};

	logic        valid_s1;
	logic [2:0]  sector_s1;
	logic [16:0] weight_s1;
	logic [16:0] val_s1;
	logic [32:0] chroma_s1;

	// ------------------------------------------------------------------
	// Stage 2: the secondary component x = chroma * weight in Q0.48, which
	// never exceeds one, and the offset m = value - chroma in Q0.32.
	// Since saturation is at most one, chroma never exceeds value and the
	// offset cannot go negative.
	// ------------------------------------------------------------------
	logic [49:0] second_full_c;
	logic [32:0] offset_c;

	assign second_full_c = {17'd0, chroma_s1} * {33'd0, weight_s1};
	assign offset_c      = {val_s1, 16'h0000} - chroma_s1;

	logic        valid_s2;
	logic [2:0]  sector_s2;
	logic [16:0] val_s2;
	logic [48:0] second_s2;
	logic [32:0] offset_s2;

	// ------------------------------------------------------------------
	// Stage 3: the secondary channel level x + m, still in Q0.48.
	// The dominant channel is chroma + m, which is the value itself, and
	// the weakest channel is m alone, so only one sum is needed here.
	// ------------------------------------------------------------------
	logic [48:0] second_sum_c;

	assign second_sum_c = second_s2 + {offset_s2[32:0], 16'h0000};

	logic        valid_s3;
	logic [2:0]  sector_s3;
	logic [16:0] val_s3;
	logic [48:0] second_sum_s3;
	logic [32:0] offset_s3;

	// ------------------------------------------------------------------
	// Stage 4: scale each of the three levels by 255 with a shift and a
	// subtract, keep the integer part, and route the levels to the
	// channels by sector. No level exceeds one, so no result exceeds 255.
	// ------------------------------------------------------------------
	logic [24:0] top_scaled_c;
	logic [56:0] mid_scaled_c;
	logic [40:0] low_scaled_c;
	logic [7:0]  top_lvl_c;
	logic [7:0]  mid_lvl_c;
	logic [7:0]  low_lvl_c;
	rgb_t        rgb_c;

	assign top_scaled_c = {val_s3, 8'h00} - {8'h00, val_s3};
	assign mid_scaled_c = {second_sum_s3, 8'h00} - {8'h00, second_sum_s3};
	assign low_scaled_c = {offset_s3, 8'h00} - {8'h00, offset_s3};
	assign top_lvl_c    = top_scaled_c[23:16];
	assign mid_lvl_c    = mid_scaled_c[55:48];
	assign low_lvl_c    = low_scaled_c[39:32];

	always_comb begin
		case (sector_s3)
			SECTOR_RED_YELLOW: begin
				rgb_c = '{red: top_lvl_c, green: mid_lvl_c, blue: low_lvl_c};
			end
			SECTOR_YELLOW_GREEN: begin
				rgb_c = '{red: mid_lvl_c, green: top_lvl_c, blue: low_lvl_c};
			end
			SECTOR_GREEN_CYAN: begin
				rgb_c = '{red: low_lvl_c, green: top_lvl_c, blue: mid_lvl_c};
			end
			SECTOR_CYAN_BLUE: begin
				rgb_c = '{red: low_lvl_c, green: mid_lvl_c, blue: top_lvl_c};
			end
			SECTOR_BLUE_MAGENTA: begin
				rgb_c = '{red: mid_lvl_c, green: low_lvl_c, blue: top_lvl_c};
			end
			default: begin
				// Magenta back round to red.
				rgb_c = '{red: top_lvl_c, green: low_lvl_c, blue: mid_lvl_c};
			end
		endcase
	end

	// Valid bits travel alongside the data and are the only reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done     <= valid_s3;
		end
	end

	// Payload registers carry no reset; a stage is loaded only when its
	// valid bit says that a beat is moving into it.
	always_ff @(posedge clk) begin
		if (accept) begin
			sector_s1 <= hue6_c[18:16];
			weight_s1 <= weight_c;
			val_s1    <= val_c;
			chroma_s1 <= chroma_full_c[32:0];
		end
		if (valid_s1) begin
			sector_s2 <= sector_s1;
			val_s2    <= val_s1;
			second_s2 <= second_full_c[48:0];
			offset_s2 <= offset_c;
		end
		if (valid_s2) begin
			sector_s3     <= sector_s2;
			val_s3        <= val_s2;
			second_sum_s3 <= second_sum_c;
			offset_s3     <= offset_s2;
		end
		if (valid_s3) begin
			rgb <= rgb_c;
		end
	end

`ifndef SYNTHESIS
	// An accepted beat always occupies the first stage on the next edge.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted beat did not reach stage 1");

	// The secondary level can never rise above the value, i.e. full scale.
	a_second_below_top: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (second_sum_s3 <= {val_s3, 32'h0000_0000}))
		else $error("secondary level exceeds the value");

	// Nor can it fall below the offset, since the secondary part is positive.
	a_second_above_low: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> ({offset_s3, 16'h0000} <= second_sum_s3))
		else $error("secondary level below the offset");

	// A result strobe only ever follows a beat in the last stage.
	a_done_from_s3: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s3))
		else $error("result strobe without a beat in stage 3");
`endif

endmodule

`default_nettype wire

// File: dv/tb_hsv_to_rgb_converter_core.sv
// Self-checking testbench for hsv_to_rgb_converter_core: corner colours, then random colours.
// A scoreboard class predicts each RGB beat and checks the strobed results in order.
// Depends on hsv2rgb_pkg for the beat types and the hue sector codes.

module tb_hsv_to_rgb_converter_core;
	timeunit 1ns;
	timeprecision 1ps;

	import hsv2rgb_pkg::*;

	localparam int RANDOM_BEATS  = 750;
	localparam int CYCLE_LIMIT   = 200000;
	// The result strobe follows acceptance through the pipeline registers, so this is ample.
	localparam int SETTLE_CYCLES = 12;
	localparam int REPORT_LIMIT  = 10;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	hsv_t hsv;
	rgb_t rgb;
	int   cycles = 0;

	hsv_to_rgb_converter_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.hsv    (hsv),
		.done   (done),
		.rgb    (rgb)
	);

	// Holds the RGB beats still owed by the block, oldest first, and counts
	// every result that is wrong or arrives with nothing owed.
	class colour_scoreboard;
		rgb_t expected_rgb[$];
		int   mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Saturation and brightness above one are pinned to one.
		function logic [16:0] clamp_unit(input logic [16:0] level);
			return (level > ONE_Q16) ? ONE_Q16 : level;
		endfunction

		// Component plus offset, scaled to 0..255 and truncated.
		function logic [7:0] to_level(input logic [63:0] comp48, input logic [63:0] off48);
			logic [63:0] scaled;
			scaled = ((comp48 + off48) * 64'd255) >> 48;
			return (scaled > 64'd255) ? 8'hFF : scaled[7:0];
		endfunction

		function rgb_t convert_hsv(input hsv_t c);
			logic [16:0] sat;
			logic [16:0] val;
			logic [18:0] hue6;
			logic [2:0]  sector;
			logic [16:0] weight;
			logic [63:0] chroma32;
			logic [63:0] chroma48;
			logic [63:0] second48;
			logic [63:0] offset48;
			logic [63:0] r48;
			logic [63:0] g48;
			logic [63:0] b48;
			rgb_t        res;
			sat      = clamp_unit(c.saturation);
			val      = clamp_unit(c.brightness);
			hue6     = {3'b000, c.hue} * 19'd6;
			sector   = hue6[18:16];
			// Rising edge of the secondary in even sectors, falling in odd ones.
			weight   = sector[0] ? (ONE_Q16 - {1'b0, hue6[15:0]}) : {1'b0, hue6[15:0]};
			chroma32 = {47'd0, val} * {47'd0, sat};
			chroma48 = chroma32 << 16;
			second48 = chroma32 * {47'd0, weight};
			offset48 = ({47'd0, val} << 32) - chroma48;
			r48 = '0;
			g48 = '0;
			b48 = '0;
			case (sector)
				SECTOR_RED_YELLOW: begin
					r48 = chroma48;
					g48 = second48;
				end
				SECTOR_YELLOW_GREEN: begin
					r48 = second48;
					g48 = chroma48;
				end
				SECTOR_GREEN_CYAN: begin
					g48 = chroma48;
					b48 = second48;
				end
				SECTOR_CYAN_BLUE: begin
					g48 = second48;
					b48 = chroma48;
				end
				SECTOR_BLUE_MAGENTA: begin
					r48 = second48;
					b48 = chroma48;
				end
				default: begin
					r48 = chroma48;
					b48 = second48;
				end
			endcase
			res.red   = to_level(r48, offset48);
			res.green = to_level(g48, offset48);
			res.blue  = to_level(b48, offset48);
			return res;
		endfunction

		function void note_colour(input hsv_t c);
			expected_rgb.push_back(convert_hsv(c));
		endfunction

		function void check_rgb(input rgb_t got);
			rgb_t want;
			if (expected_rgb.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
				return;
			end
			want = expected_rgb.pop_front();
			if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("rgb mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
						want.red, want.green, want.blue, got.red, got.green, got.blue);
			end
		endfunction

		function int pending();
			return expected_rgb.size();
		endfunction
	endclass

	colour_scoreboard board;

	// Corner colours: every sector boundary, both ends of the hue range, grey,
	// black, full value, and saturation and brightness at and above one.
	hsv_t corner_colours[20] = '{
		'{16'h0000, 17'h10000, 17'h10000},
		'{16'd10922, 17'h10000, 17'h10000},
		'{16'd10923, 17'h10000, 17'h10000},
		'{16'd21845, 17'h10000, 17'h10000},
		'{16'd21846, 17'h10000, 17'h10000},
		'{16'd32768, 17'h10000, 17'h10000},
		'{16'd43691, 17'h10000, 17'h10000},
		'{16'd54614, 17'h10000, 17'h10000},
		'{16'hFFFF, 17'h10000, 17'h10000},
		'{16'h1234, 17'h00000, 17'h10000},
		'{16'h9ABC, 17'h10000, 17'h00000},
		'{16'h5555, 17'h1FFFF, 17'h1FFFF},
		'{16'hAAAA, 17'h10001, 17'h10001},
		'{16'h5555, 17'h0FFFF, 17'h0FFFF},
		'{16'hAAAA, 17'h10000, 17'h08000},
		'{16'd5461, 17'h08000, 17'h10000},
		'{16'd27306, 17'h00001, 17'h10000},
		'{16'hFFFF, 17'h1FFFF, 17'h00000},
		'{16'h8000, 17'h00000, 17'h1FFFF},
		'{16'h0001, 17'h00001, 17'h00001}
	};

	always #1 clk = ~clk;

	// The run is cut short if the block stops delivering results.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// The receiver cannot push back, so every strobed beat is checked at the
	// edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_rgb(rgb);
	end

	// Mostly in range, with exact zero and one favoured and a share of values
	// above one so that every bit of the field toggles.
	function automatic logic [16:0] random_unit();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return 17'd0;
		else if (roll < 16)
			return ONE_Q16;
		else if (roll < 85)
			return 17'($urandom_range(0, 65536));
		else
			return 17'($urandom_range(0, 131071));
	endfunction

	function automatic logic [15:0] random_hue();
		int roll;
		roll = $urandom_range(0, 99);
		// Land on or next to a sector boundary now and then.
		if (roll < 10)
			return 16'(($urandom_range(0, 5) * 65536 + 5) / 6 + $urandom_range(0, 2) - 1);
		else
			return 16'($urandom_range(0, 65535));
	endfunction

	function automatic int random_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 96)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Idles for the given number of cycles, presents one beat and returns at
	// the edge that accepts it; the input carries junk while start is low.
	task automatic send_colour(input hsv_t c, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			hsv   <= hsv_t'(50'({$urandom(), $urandom()}));
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		hsv   <= c;
		do
			@(posedge clk);
		while (busy);
		board.note_colour(c);
	endtask

	// Holds the sender off until every beat owed by the block has come back.
	task automatic drain_results();
		start <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		hsv_t colour;
		int   gap;
		board  = new();
		clk    = 1'b0;
		arst_n = 1'b0;
		start  = 1'b0;
		hsv    = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_colours[k])
			send_colour(corner_colours[k], (k % 4 == 3) ? 1 : 0);
		drain_results();

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			colour.hue        = random_hue();
			colour.saturation = random_unit();
			colour.brightness = random_unit();
			// Runs of back-to-back beats between the stretches with gaps.
			gap = (i % 200 < 40) ? 0 : random_gap();
			send_colour(colour, gap);
			if (i % 250 == 249)
				drain_results();
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: files.f
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv_to_rgb_converter_core.sv
dv/tb_hsv_to_rgb_converter_core.sv
